[design/tbrr_pkg.sv]
package tbrr_pkg;

    // Sizing of the pacer
    localparam int BURST      = 32;
    localparam int MAX_FLOWS  = 64;
    localparam int MAX_EMIT   = 32;

    // Field widths
    localparam int FRAC_W     = 32;
    localparam int RATE_W     = 40;
    localparam int FLOW_CNT_W = 7;
    localparam int NOW_W      = 64;
    localparam int BUFS_W     = 6;
    localparam int FLOW_IDX_W = 6;

    // Token level holds up to BURST whole tokens plus the fraction
    localparam int WHOLE_W    = $clog2(BURST + 1);
    localparam int LEVEL_W    = WHOLE_W + FRAC_W;
    localparam int GEN_W      = $clog2(MAX_EMIT + 1);

    // Digit-serial multiply of elapsed time by rate, MSB digit first
    localparam int DIGIT_W    = 8;
    localparam int DIGITS     = NOW_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(DIGITS);
    localparam int PP_W       = RATE_W + DIGIT_W;
    localparam int SUM_W      = PP_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_PER_CYCLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_COUNT     = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // capture request, start elapsed-time multiply
        logic mul_step;  // run one multiply digit
        logic load;      // add tokens, store poll time
        logic gen;       // take emit count off the tokens, load first flow
        logic advance;   // result taken, move to next flow
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic active;    // enabled, nonzero rate and flows
        logic mul_done;  // last multiply digit in this cycle
        logic gen_zero;  // nothing to emit on this poll
        logic last;      // current result is the final one
    } t_sts;

endpackage

[design/tbrr_in_if.sv]
interface tbrr_in_if;
    import tbrr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [NOW_W-1:0]      now_cycles;
    logic [BUFS_W-1:0]     free_buffers;

    modport source (output valid, output now_cycles, output free_buffers, input ready);
    modport sink   (input valid, input now_cycles, input free_buffers, output ready);
endinterface

[design/tbrr_out_if.sv]
interface tbrr_out_if;
    import tbrr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FLOW_IDX_W-1:0] flow_index;
    logic                  last;

    modport source (output valid, output flow_index, output last, input ready);
    modport sink   (input valid, input flow_index, input last, output ready);
endinterface

[design/tbrr_ctrl.sv]
module tbrr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  tbrr_pkg::t_sts i_sts,
    output tbrr_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);
    import tbrr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_GEN  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.active) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_GEN;
            end
            S_GEN: begin
                o_cmd.gen = 1'b1;
                n_state   = i_sts.gen_zero ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.advance = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/tbrr_dp.sv]
module tbrr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbrr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbrr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [tbrr_pkg::NOW_W-1:0]         i_now_cycles,
    input  logic [tbrr_pkg::BUFS_W-1:0]        i_free_buffers,
    input  tbrr_pkg::t_cmd                     i_cmd,
    output tbrr_pkg::t_sts                     o_sts,
    output logic [tbrr_pkg::FLOW_IDX_W-1:0]    o_flow_index,
    output logic                               o_last
);
    import tbrr_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_CAP = {WHOLE_W'(BURST), FRAC_W'(0)};

    // Configuration
    logic                  r_run_enable;
    logic [RATE_W-1:0]     r_rate;
    logic [FLOW_CNT_W-1:0] r_flow_count;

    // Architectural state
    logic [LEVEL_W-1:0]    r_level;
    logic [NOW_W-1:0]      r_last_poll;
    logic [FLOW_IDX_W-1:0] r_next_flow;

    // Per-request work registers
    logic [NOW_W-1:0]      r_now;
    logic [BUFS_W-1:0]     r_bufs;
    logic [NOW_W-1:0]      r_elapsed;
    logic [LEVEL_W-1:0]    r_acc;
    logic [LEVEL_W-1:0]    r_thr;
    logic                  r_sat;
    logic [DIG_CNT_W-1:0]  r_dig;
    logic [FLOW_IDX_W-1:0] r_rr;
    logic [GEN_W-1:0]      r_left;

    logic [FLOW_CNT_W-1:0] w_flows;
    logic [DIGIT_W-1:0]    w_digit;
    logic [PP_W-1:0]       w_pp;
    logic [SUM_W-1:0]      w_sum;
    logic [7:0]            w_whole;
    logic [7:0]            w_bufs;
    logic [7:0]            w_min;
    logic [GEN_W-1:0]      w_gen;
    logic [FLOW_IDX_W-1:0] w_rr_start;
    logic [FLOW_CNT_W-1:0] w_rr_inc;
    logic [FLOW_IDX_W-1:0] w_rr_next;

    // Clamp flow count to the template table size
    assign w_flows = (r_flow_count > FLOW_CNT_W'(MAX_FLOWS)) ? FLOW_CNT_W'(MAX_FLOWS)
                                                             : r_flow_count;

    // One multiply digit: acc * 2^DIGIT_W + digit * rate
    assign w_digit = r_elapsed[NOW_W-1 -: DIGIT_W];
    assign w_pp    = w_digit * r_rate;
    assign w_sum   = SUM_W'({r_acc, DIGIT_W'(0)}) + SUM_W'(w_pp);

    // Emit count: smallest of whole tokens, free buffers and the per-poll limit
    always_comb begin
        w_whole = 8'(r_level[LEVEL_W-1:FRAC_W]);
        w_bufs  = 8'(r_bufs);
        w_min   = (w_whole < w_bufs) ? w_whole : w_bufs;
        if (w_min > 8'(MAX_EMIT)) begin
            w_min = 8'(MAX_EMIT);
        end
        w_gen = GEN_W'(w_min);
    end

    // Round-robin start and step, restart at flow zero when out of range
    assign w_rr_start = ({1'b0, r_next_flow} >= w_flows) ? '0 : r_next_flow;
    assign w_rr_inc   = FLOW_CNT_W'(r_rr) + FLOW_CNT_W'(1);
    assign w_rr_next  = (w_rr_inc >= w_flows) ? '0 : r_rr + FLOW_IDX_W'(1);

    assign o_sts.active   = r_run_enable && (r_rate != '0) && (w_flows != '0);
    assign o_sts.mul_done = (r_dig == DIG_CNT_W'(DIGITS - 1));
    assign o_sts.gen_zero = (w_gen == '0);
    assign o_sts.last     = (r_left == '0);

    assign o_flow_index = r_rr;
    assign o_last       = (r_left == '0);

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= 1'b0;
            r_rate       <= '0;
            r_flow_count <= '0;
            r_level      <= '0;
            r_last_poll  <= '0;
            r_next_flow  <= '0;
            r_dig        <= '0;
            r_sat        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RUN_ENABLE:     r_run_enable <= i_cfg_data[0];
                    CFG_RATE_PER_CYCLE: r_rate       <= i_cfg_data[RATE_W-1:0];
                    CFG_FLOW_COUNT:     r_flow_count <= i_cfg_data[FLOW_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_dig <= '0;
                r_sat <= 1'b0;
            end
            if (i_cmd.mul_step) begin
                r_dig <= r_dig + DIG_CNT_W'(1);
                if (w_sum >= SUM_W'(r_thr)) begin
                    r_sat <= 1'b1;
                end
            end
            // Saturate at the burst cap, else add the product
            if (i_cmd.load) begin
                r_level     <= r_sat ? LEVEL_CAP : r_level + r_acc;
                r_last_poll <= r_now;
            end
            if (i_cmd.gen) begin
                r_level <= r_level - LEVEL_W'({w_gen, FRAC_W'(0)});
            end
            if (i_cmd.advance) begin
                r_next_flow <= w_rr_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now     <= i_now_cycles;
            r_bufs    <= i_free_buffers;
            r_elapsed <= i_now_cycles - r_last_poll;
            r_acc     <= '0;
            r_thr     <= LEVEL_CAP - r_level;
        end
        if (i_cmd.mul_step) begin
            r_elapsed <= {r_elapsed[NOW_W-DIGIT_W-1:0], DIGIT_W'(0)};
            // Keep the partial product only while below the headroom
            if (!r_sat && (w_sum < SUM_W'(r_thr))) begin
                r_acc <= LEVEL_W'(w_sum);
            end
        end
        if (i_cmd.gen) begin
            r_rr   <= w_rr_start;
            r_left <= w_gen - GEN_W'(1);
        end
        if (i_cmd.advance) begin
            r_rr   <= w_rr_next;
            r_left <= r_left - GEN_W'(1);
        end
    end

endmodule

[design/token_bucket_round_robin_pacer_core.sv]
// Channel   Dir  Payload                     Handshake
// i_req     in   now_cycles, free_buffers    valid/ready, one poll per request
// o_res     out  flow_index, last            valid/ready, up to 32 packets per request
// i_cfg_*   in   index, data                 write enable, no back-pressure
//
// An inactive poll is dropped without leaving idle. An active poll emits N
// packets (N up to 32): the 8-bit-digit multiply of elapsed time by rate,
// then a state that adds tokens, a state that takes the emit count, then one packet per
// cycle from the output register, each held while o_res.ready is low.
// i_req.ready is high only between polls. Synchronous active-low reset clears
// the configuration and the token, poll-time and round-robin state to zero.
module token_bucket_round_robin_pacer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tbrr_in_if.sink                         i_req,
    tbrr_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [tbrr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbrr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tbrr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tbrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid)
    );

    tbrr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_now_cycles   (i_req.now_cycles),
        .i_free_buffers (i_req.free_buffers),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_flow_index   (o_res.flow_index),
        .o_last         (o_res.last)
    );

    // Final packet of a poll ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last) |=> !o_res.valid)
        else $error("result valid after final packet");

    // A run continues until its final packet
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last) |=> o_res.valid)
        else $error("run stopped before final packet");

    // Inactive poll is dropped at once
    a_inactive_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !w_sts.active) |=> i_req.ready)
        else $error("inactive poll not dropped");

    // No new poll while packets are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready)
        else $error("poll accepted during a run");

endmodule
